// File: hw/rtl/fbfla_pkg.sv
// ----------------------------------------------------------------------------
// fbfla_pkg: shared definitions for the fixed block free list allocator
// Widths, link codes, status codes, register indexes and the divider
// request/response structs.
// ----------------------------------------------------------------------------
package fbfla_pkg;

   // pool depth and derived widths
   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int LINK_W     = IDX_W + 1;

   // payload widths
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 16;
   localparam int COUNT_W    = 11;
   localparam int STAT_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_CNT_W  = $clog2(ADDR_W);

   // link store codes beyond any block index
   localparam logic [LINK_W-1:0] LINK_END = {LINK_W{1'b1}};
   localparam logic [LINK_W-1:0] LINK_DET = {{(LINK_W-1){1'b1}}, 1'b0};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   // register reset values
   localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
   localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd64;
   localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_EXHAUSTED = 3'd1,
      ST_UNALIGNED = 3'd2,
      ST_RANGE     = 3'd3,
      ST_DOUBLE    = 3'd4
   } status_type;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   // divider handshake
   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_rsp_type;

endpackage

// File: hw/rtl/fbfla_ram.sv
// ----------------------------------------------------------------------------
// fbfla_ram: generic single write port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module fbfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/fbfla_div.sv
// ----------------------------------------------------------------------------
// fbfla_div: iterative restoring divider
// Divides a 32-bit value by a nonzero 16-bit value, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fbfla_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fbfla_pkg::div_req_type div_req,
   output fbfla_pkg::div_rsp_type div_rsp
);
   import fbfla_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [SIZE_W-1:0]    dsr_ff, dsr_in;
   logic [ADDR_W-1:0]    quo_ff, quo_in;
   logic [SIZE_W:0]      trial;
   logic [SIZE_W:0]      diff;

   // one shift-subtract step per cycle; dividend shifts out as quotient shifts in
   always_comb begin
      trial   = {rem_ff, quo_ff[ADDR_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[SIZE_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SIZE_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// File: hw/rtl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator: free list allocator for equal-size blocks
// Pops and pushes block indexes on a linked free list held in a link RAM;
// release addresses are checked for alignment, range and double free.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | command, address
//   rsp     | out       | rsp_valid/stall    | status, block_address, free_count
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// Allocate runs S_ALLOC (skipped on an empty pool), release S_OFFSET, S_DIVIDE
// (32 one-bit steps), S_CHECK and, if that passes, S_FREE; both end in S_DONE.
// The next request is taken once the result sits in the output register.
// No clearing pass: link entries at or above the fresh mark read as the initial
// chain, so reset and a register write rebuild it via head, free count and fresh mark.
// A stalled result holds in the output register; the sequencer waits in its
// final state until that register is free.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [fbfla_pkg::ADDR_W-1:0]      req_address,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fbfla_pkg::STAT_W-1:0]      rsp_status,
   output logic [fbfla_pkg::ADDR_W-1:0]      rsp_block_address,
   output logic [fbfla_pkg::COUNT_W-1:0]     rsp_free_count,
   // register write port
   input  logic                              csr_we,
   input  logic [fbfla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbfla_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fbfla_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_ALLOC  = 7'b0000010,
      S_OFFSET = 7'b0000100,
      S_DIVIDE = 7'b0001000,
      S_CHECK  = 7'b0010000,
      S_FREE   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   localparam int PROD_W = IDX_W + SIZE_W;

   // block count clamped to the built depth
   function automatic logic [LINK_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
      logic [LINK_W-1:0] r;
      if (32'(c) > 32'(MAX_BLOCKS)) begin
         r = LINK_W'(MAX_BLOCKS);
      end else begin
         r = LINK_W'(c);
      end
      return r;
   endfunction

   // link of an entry that still holds its rebuilt value
   function automatic logic [LINK_W-1:0] chain_link(input logic [IDX_W-1:0] idx,
                                                    input logic [LINK_W-1:0] n);
      logic [LINK_W-1:0] nxt;
      nxt = {1'b0, idx} + 1'b1;
      return (nxt < n) ? nxt : LINK_END;
   endfunction

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   free_ff, free_in;
   logic [LINK_W-1:0]   fresh_ff, fresh_in;
   logic                cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                neg_ff, neg_in;
   status_type          stat_ff, stat_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;

   logic [SIZE_W-1:0]   eff_size;
   logic [LINK_W-1:0]   eff_count;
   logic [LINK_W-1:0]   new_count;
   logic [LINK_W-1:0]   link_val;
   logic [ADDR_W-1:0]   offset;
   logic                req_take;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [LINK_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [IDX_W-1:0]    ram_raddr;
   logic [LINK_W-1:0]   ram_rdata;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // link store
   fbfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // divider for the release offset
   fbfla_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // effective configuration and current link
   always_comb begin
      eff_size  = (size_ff == '0) ? SIZE_W'(1) : size_ff;
      eff_count = clamp_count(count_ff);
      new_count = clamp_count((csr_index == CSR_COUNT) ? csr_wdata[COUNT_W-1:0] : count_ff);
      link_val  = ({1'b0, idx_ff} < fresh_ff) ? ram_rdata : chain_link(idx_ff, eff_count);
      offset    = addr_ff - base_ff;
   end

   assign req_stall = (state_ff != S_IDLE) || csr_we;
   assign req_take  = req_valid && !req_stall;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      fresh_in      = fresh_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      neg_in        = neg_ff;
      stat_in       = stat_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_free_in   = rsp_free_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = LINK_DET;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff;
      div_req.start    = 1'b0;
      div_req.dividend = offset[ADDR_W-1] ? (ADDR_W'(0) - offset) : offset;
      div_req.divisor  = eff_size;

      // output register drains on transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in  = req_command;
               addr_in = req_address;
               if (req_command == CMD_RELEASE) begin
                  state_in = S_OFFSET;
               end else if (head_ff >= LINK_W'(MAX_BLOCKS)) begin
                  stat_in  = ST_EXHAUSTED;
                  state_in = S_DONE;
               end else begin
                  idx_in    = head_ff[IDX_W-1:0];
                  ram_re    = 1'b1;
                  ram_raddr = head_ff[IDX_W-1:0];
                  state_in  = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            // unlink head, mark it detached
            head_in = link_val;
            ram_we  = 1'b1;
            if ({1'b0, idx_ff} == fresh_ff) begin
               fresh_in = fresh_ff + 1'b1;
            end
            if (free_ff != '0) begin
               free_in = free_ff - 1'b1;
            end
            prod_in  = PROD_W'(idx_ff) * PROD_W'(eff_size);
            stat_in  = ST_OK;
            state_in = S_DONE;
         end
         S_OFFSET: begin
            neg_in        = offset[ADDR_W-1];
            div_req.start = 1'b1;
            state_in      = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // alignment first, then range
            if (div_rsp.remainder != '0) begin
               stat_in  = ST_UNALIGNED;
               state_in = S_DONE;
            end else if (neg_ff || (div_rsp.quotient >= ADDR_W'(eff_count))) begin
               stat_in  = ST_RANGE;
               state_in = S_DONE;
            end else begin
               idx_in    = div_rsp.quotient[IDX_W-1:0];
               ram_re    = 1'b1;
               ram_raddr = div_rsp.quotient[IDX_W-1:0];
               state_in  = S_FREE;
            end
         end
         S_FREE: begin
            // push back at head if the block is detached
            if (link_val != LINK_DET) begin
               stat_in = ST_DOUBLE;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = head_ff;
               head_in   = {1'b0, idx_ff};
               free_in   = free_ff + 1'b1;
               stat_in   = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_addr_in   = ((cmd_ff == CMD_ALLOC) && (stat_ff == ST_OK)) ?
                               (base_ff + ADDR_W'(prod_ff)) : '0;
               rsp_free_in   = COUNT_W'(free_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write rebuilds the free list
      if (csr_we) begin
         case (csr_index)
            CSR_BASE:  base_in  = csr_wdata[ADDR_W-1:0];
            CSR_SIZE:  size_in  = csr_wdata[SIZE_W-1:0];
            CSR_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            default:   ;
         endcase
         if ((csr_index == CSR_BASE) || (csr_index == CSR_SIZE) ||
             (csr_index == CSR_COUNT)) begin
            head_in  = (new_count == '0) ? LINK_END : '0;
            free_in  = new_count;
            fresh_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= BASE_RST;
         size_ff      <= SIZE_RST;
         count_ff     <= COUNT_RST;
         head_ff      <= '0;
         free_ff      <= clamp_count(COUNT_RST);
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      neg_ff        <= neg_in;
      stat_ff       <= stat_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_free_count    = rsp_free_ff;

   // free count never exceeds the pool
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= LINK_W'(MAX_BLOCKS))
      else $error("free count above pool depth");

   // head is empty, a written entry, or the fresh mark
   a_head_fresh: assert property (@(posedge clock) disable iff (reset)
      (head_ff == LINK_END) || (head_ff <= fresh_ff))
      else $error("head beyond fresh mark");

   // failed commands return no address
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_block_address == '0))
      else $error("address on failed command");

   // divider only runs while the sequencer waits on it
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> (state_ff == S_DIVIDE))
      else $error("divider busy outside divide state");

endmodule

// File: bench/tb_fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator: self-checking bench for the allocator
// A scripted run covers the address extremes, every status and the register
// corner cases. Random phases follow, each starting with register writes,
// mixing allocate and release traffic with random idling on both sides.
// Each result is checked against its scripted value or a bench-side model of the free list.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator;
   import fbfla_pkg::*;

   localparam int RANDOM_ITEMS   = 1066;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 50;
   localparam int HOLD_AT_ITEM   = 150;
   localparam int CALM_FIRST     = 500;
   localparam int CALM_LAST      = 700;

   // register index past the end of the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  block_address;
      logic [COUNT_W-1:0] free_count;
   } alloc_result_type;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_REG  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      command_type          cmd;
      logic [CSR_IDX_W-1:0] reg_sel;
      logic [ADDR_W-1:0]    value;
      logic                 typed;
      alloc_result_type     want;
   } script_row_type;

   localparam alloc_result_type PREDICTED = '{ST_OK, 32'd0, 11'd0};

   // directed script; value is the release address or the register data
   localparam script_row_type SCRIPT [0:33] = '{
      // defaults after reset: base 0, size 64, full pool
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'd64, 11'd1022}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_DOUBLE, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0000_0021, 1'b1,
        '{ST_UNALIGNED, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0001_0000, 1'b1,
        '{ST_RANGE, 32'd0, 11'd1023}},
      // negative offsets: aligned is out of range, otherwise unaligned
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'hFFFF_FFC0, 1'b1,
        '{ST_RANGE, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'hFFFF_FFFF, 1'b1,
        '{ST_UNALIGNED, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0000_0040, 1'b1, '{ST_OK, 32'd0, 11'd1024}},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b0, PREDICTED},
      // base near the top, so block addresses wrap
      '{ROW_REG,  CMD_ALLOC,   CSR_BASE,  32'hFFFF_FFF0, 1'b0, PREDICTED},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_OK, 32'hFFFF_FFF0, 11'd1023}},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_OK, 32'h0000_0030, 11'd1022}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0000_0030, 1'b1, '{ST_OK, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0000_0000, 1'b0, PREDICTED},
      // zero block size acts as one; upper data bits are ignored
      '{ROW_REG,  CMD_ALLOC,   CSR_SIZE,  32'hABCD_0000, 1'b0, PREDICTED},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_OK, 32'hFFFF_FFF0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'hFFFF_FFF1, 1'b1,
        '{ST_DOUBLE, 32'd0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'hFFFF_FFEF, 1'b1,
        '{ST_RANGE, 32'd0, 11'd1023}},
      // empty pool
      '{ROW_REG,  CMD_ALLOC,   CSR_COUNT, 32'h0000_0000, 1'b0, PREDICTED},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_EXHAUSTED, 32'd0, 11'd0}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'hFFFF_FFF0, 1'b1, '{ST_RANGE, 32'd0, 11'd0}},
      // count above the built depth is clipped
      '{ROW_REG,  CMD_ALLOC,   CSR_COUNT, 32'hFFFF_FFFF, 1'b0, PREDICTED},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_OK, 32'hFFFF_FFF0, 11'd1023}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h0000_03F0, 1'b1,
        '{ST_RANGE, 32'd0, 11'd1023}},
      // single block of the largest size
      '{ROW_REG,  CMD_ALLOC,   CSR_BASE,  32'h1234_5678, 1'b0, PREDICTED},
      '{ROW_REG,  CMD_ALLOC,   CSR_SIZE,  32'h0000_FFFF, 1'b0, PREDICTED},
      '{ROW_REG,  CMD_ALLOC,   CSR_COUNT, 32'h0000_0001, 1'b0, PREDICTED},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_OK, 32'h1234_5678, 11'd0}},
      // write past the register list must not rebuild the pool
      '{ROW_REG,  CMD_ALLOC,   CSR_SPARE, 32'h5A5A_5A5A, 1'b0, PREDICTED},
      '{ROW_ITEM, CMD_ALLOC,   CSR_BASE,  32'h0000_0000, 1'b1,
        '{ST_EXHAUSTED, 32'd0, 11'd0}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h1235_5677, 1'b1, '{ST_RANGE, 32'd0, 11'd0}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h1234_5678, 1'b1, '{ST_OK, 32'd0, 11'd1}},
      '{ROW_ITEM, CMD_RELEASE, CSR_BASE,  32'h1234_5679, 1'b1,
        '{ST_UNALIGNED, 32'd0, 11'd1}}
   };

   // DUT ports
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic                  req_command = 1'b0;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [STAT_W-1:0]     rsp_status;
   logic [ADDR_W-1:0]     rsp_block_address;
   logic [COUNT_W-1:0]    rsp_free_count;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // free list model
   logic [ADDR_W-1:0]  reg_base;
   logic [SIZE_W-1:0]  reg_size;
   logic [COUNT_W-1:0] reg_count;
   logic [LINK_W-1:0]  pool_link [MAX_BLOCKS];
   logic [LINK_W-1:0]  pool_head;
   int                 pool_free;
   int                 held_blocks [$];

   alloc_result_type pending_results [$];
   int               errors     = 0;
   bit               calm       = 1'b0;
   bit               hold_start = 1'b0;

   fixed_block_free_list_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_free_count    (rsp_free_count),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] effective_size();
      return (reg_size == '0) ? 32'd1 : 32'(reg_size);
   endfunction

   function automatic int effective_count();
      return (reg_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(reg_count);
   endfunction

   // chain every block in order and free them all
   function automatic void rebuild_pool();
      int n;
      n = effective_count();
      for (int i = 0; i < MAX_BLOCKS; i++)
         pool_link[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_END;
      pool_head = (n == 0) ? LINK_END : '0;
      pool_free = n;
      held_blocks.delete();
   endfunction

   function automatic void model_register_write(input logic [CSR_IDX_W-1:0] sel,
                                                input logic [CSR_DATA_W-1:0] data);
      case (sel)
         CSR_BASE: begin
            reg_base = data;
            rebuild_pool();
         end
         CSR_SIZE: begin
            reg_size = data[SIZE_W-1:0];
            rebuild_pool();
         end
         CSR_COUNT: begin
            reg_count = data[COUNT_W-1:0];
            rebuild_pool();
         end
         default: ;
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] req_offset(input logic [ADDR_W-1:0] addr);
      return addr - reg_base;
   endfunction

   // expected result of one command; updates the model
   function automatic alloc_result_type predict_command(input command_type cmd,
                                                        input logic [ADDR_W-1:0] addr);
      alloc_result_type res;
      logic [ADDR_W-1:0] bs, offset, mag, idx;
      bs  = effective_size();
      res = '{ST_OK, 32'd0, 11'd0};
      if (cmd == CMD_ALLOC) begin
         if (pool_head >= MAX_BLOCKS) begin
            res.status = ST_EXHAUSTED;
         end else begin
            idx = 32'(pool_head);
            pool_head = pool_link[idx];
            pool_link[idx] = LINK_DET;
            if (pool_free > 0) pool_free--;
            res.block_address = reg_base + idx * bs;
            held_blocks.push_back(int'(idx));
         end
      end else begin
         offset = req_offset(addr);
         if (offset[ADDR_W-1]) begin
            mag = 32'd0 - offset;
            if (mag % bs != 0) res.status = ST_UNALIGNED;
            else res.status = ST_RANGE;
         end else if (offset % bs != 0) begin
            res.status = ST_UNALIGNED;
         end else begin
            idx = offset / bs;
            if (idx >= effective_count()) begin
               res.status = ST_RANGE;
            end else if (pool_link[idx] != LINK_DET) begin
               res.status = ST_DOUBLE;
            end else begin
               pool_link[idx] = pool_head;
               pool_head = LINK_W'(idx);
               pool_free++;
               for (int j = 0; j < held_blocks.size(); j++) begin
                  if (held_blocks[j] == int'(idx)) begin
                     held_blocks.delete(j);
                     break;
                  end
               end
            end
         end
      end
      res.free_count = COUNT_W'(pool_free);
      return res;
   endfunction

   // mostly live blocks, then double frees, misaligned, out-of-range and fully random addresses
   function automatic logic [ADDR_W-1:0] pick_release_address();
      logic [ADDR_W-1:0] bs, idx;
      int n, r;
      bs  = effective_size();
      n   = effective_count();
      r   = $urandom_range(99);
      idx = (n > 0) ? 32'($urandom_range(n - 1, 0)) : 32'd0;
      if (r < 60 && held_blocks.size() != 0)
         return reg_base + 32'(held_blocks[$urandom_range(held_blocks.size() - 1, 0)]) * bs;
      if (r < 70) return reg_base + idx * bs;
      if (r < 78 && bs > 1) return reg_base + idx * bs + 32'($urandom_range(bs - 1, 1));
      if (r < 86) return reg_base + 32'($urandom_range(n + 8, n)) * bs;
      if (r < 92) return reg_base - 32'($urandom_range(8, 1)) * bs;
      return $urandom;
   endfunction

   // register data with extremes; bits above the register width stay random
   function automatic logic [CSR_DATA_W-1:0] pick_register_value(
         input logic [CSR_IDX_W-1:0] sel);
      logic [CSR_DATA_W-1:0] data;
      int r;
      data = $urandom;
      r    = $urandom_range(9);
      case (sel)
         CSR_BASE: begin
            if (r == 0) data = '0;
            else if (r == 1) data = '1;
         end
         CSR_SIZE: begin
            if (r == 0) data[SIZE_W-1:0] = '0;
            else if (r == 1) data[SIZE_W-1:0] = 16'd1;
            else if (r == 2) data[SIZE_W-1:0] = 16'hFFFF;
            else if (r < 7) data[SIZE_W-1:0] = 16'($urandom_range(128, 1));
         end
         CSR_COUNT: begin
            // small pools most of the time so that they run dry
            if (r == 0) data[COUNT_W-1:0] = '0;
            else if (r == 1) data[COUNT_W-1:0] = 11'd1024;
            else if (r == 2) data[COUNT_W-1:0] = '1;
            else if (r < 9) data[COUNT_W-1:0] = 11'($urandom_range(24, 1));
         end
         default: ;
      endcase
      return data;
   endfunction

   // one request transfer; returns at the accepting edge
   task automatic send_item(input command_type cmd, input logic [ADDR_W-1:0] addr,
                            input logic typed, input alloc_result_type want);
      alloc_result_type predicted;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_command(cmd, addr);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // register write once the block has gone idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] sel,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      model_register_write(sel, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stimulus
   initial begin
      int sent, phase_len, alloc_pct, n_writes;
      logic [CSR_IDX_W-1:0] sel;
      reg_base  = BASE_RST;
      reg_size  = SIZE_RST;
      reg_count = COUNT_RST;
      rebuild_pool();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[r]) begin
         if (SCRIPT[r].kind == ROW_REG)
            write_register(SCRIPT[r].reg_sel, SCRIPT[r].value);
         else
            send_item(SCRIPT[r].cmd, SCRIPT[r].value, SCRIPT[r].typed, SCRIPT[r].want);
      end

      // random phases, each with its own register setting and traffic mix
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         n_writes = $urandom_range(3, 1);
         repeat (n_writes) begin
            sel = CSR_IDX_W'($urandom_range(3, 0));
            write_register(sel, pick_register_value(sel));
         end
         phase_len = $urandom_range(120, 40);
         if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
         alloc_pct = 30 + 20 * $urandom_range(2, 0);
         repeat (phase_len) begin
            if ($urandom_range(99) < alloc_pct)
               send_item(CMD_ALLOC, $urandom, 1'b0, PREDICTED);
            else
               send_item(CMD_RELEASE, pick_release_address(), 1'b0, PREDICTED);
            sent++;
            calm = (sent >= CALM_FIRST && sent < CALM_LAST);
            if (sent == HOLD_AT_ITEM) hold_start = 1'b1;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // response side stall, with one long hold-off while requests keep coming
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 10);
         end
      end
   end

   // result checker
   initial begin
      alloc_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with nothing expected: status %0d", rsp_status);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_block_address !== want.block_address) begin
                  $error("block_address: expected %h, got %h",
                         want.block_address, rsp_block_address);
                  errors++;
               end
               if (rsp_free_count !== want.free_count) begin
                  $error("free_count: expected %0d, got %0d", want.free_count, rsp_free_count);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog: cycles without any transfer on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

endmodule
